[hdl/pwps_pkg.sv]
// Shared types and fixed constants of the PWM prescaler and period search unit.
// Used by the divider and by the top level; depends on nothing.
`default_nettype none

package pwps_pkg;

	// Field and datapath widths.
	localparam int CLK_W  = 27;
	localparam int FREQ_W = 16;
	localparam int PER_W  = 16;
	localparam int DVD_W  = 27;
	localparam int DVSR_W = 16;
	localparam int CNT_W  = $clog2(DVD_W);

	// Timer clock after reset and rounding threshold of the total count.
	localparam logic [CLK_W-1:0]  CLOCK_RESET = 27'd72000000;
	localparam logic [DVSR_W-1:0] ROUND_THR   = 16'd32768;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CNT_START,
		ST_CNT_WAIT,
		ST_TRY_START,
		ST_TRY_WAIT,
		ST_DONE
	} state_t;

endpackage

`default_nettype wire

[hdl/pwps_div.sv]
// Iterative restoring divider, one quotient bit per cycle.
// Uses the widths of pwps_pkg.
`default_nettype none

module pwps_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [pwps_pkg::DVD_W-1:0]   dividend,
	input  logic [pwps_pkg::DVSR_W-1:0]  divisor,
	output logic                         done,
	output logic [pwps_pkg::DVD_W-1:0]   quot,
	output logic [pwps_pkg::DVSR_W-1:0]  rem
);
	import pwps_pkg::*;

	logic               busy_q;
	logic               done_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [DVD_W-1:0]   quo_q;
	logic [DVSR_W-1:0]  rem_q;
	logic [DVSR_W-1:0]  dvsr_q;
	logic [DVSR_W:0]    trial;
	logic               fits;
	logic [DVSR_W:0]    diff;

	// One restoring step: shift in the next dividend bit and try to subtract.
	always_comb begin
		trial = {rem_q, quo_q[DVD_W-1]};
		fits  = trial >= {1'b0, dvsr_q};
		diff  = trial - {1'b0, dvsr_q};
	end

	// Control: busy while steps remain, done pulses once the last step has landed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CNT_W'(DVD_W - 1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DVD_W - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// Datapath: partial remainder and quotient shift register.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			quo_q  <= dividend;
			dvsr_q <= divisor;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= diff[DVSR_W-1:0];
			end else begin
				rem_q <= trial[DVSR_W-1:0];
			end
			quo_q <= {quo_q[DVD_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quot = quo_q;
	assign rem  = rem_q;

	// The pulse comes only after a full run of steps.
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q))
		else $error("divider done without a run");

	// A new start never lands in the middle of a run.
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q || (cnt_q == '0 && $past(start)) || !busy_q)
		else $error("divider restarted while busy");

	// When done pulses, the remainder is below the divisor.
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> rem_q < dvsr_q)
		else $error("divider remainder out of range");

endmodule

`default_nettype wire

[hdl/pwm_prescaler_period_search_unit.sv]
// Top level of the PWM prescaler and period search unit: sequencer, registers and I/O.
// Depends on pwps_pkg and on the shared divider pwps_div.
//
// channel  direction  handshake             contents
// cfg      in         cfg_valid/cfg_ready   clock_hz [26:0]
// s        in         s_tvalid/s_tready     frequency [15:0]
// m        out        m_tvalid/m_tready     prescale, period, exact
//
// Each request runs one division for the total count and then one per divisor tried,
// from 1 up to MAX_PRESCALE, stopping at the first exact fit; a zero frequency skips
// the divider. The single shared divider does them one after another, 27 steps each.
// s_tready is high only while the sequencer is idle; a result waits in the output
// register, and the next request is taken as soon as that result is loaded there.
// Reset restores clock_hz to 72 MHz and empties the output register.
`default_nettype none

module pwm_prescaler_period_search_unit #(
	parameter int MAX_PRESCALE = 1200,
	parameter int PERIOD_LIMIT = 65535,
	localparam int PSC_W   = $clog2(MAX_PRESCALE + 1),
	localparam int TDATA_W = ((PSC_W + pwps_pkg::PER_W + 1 + 7) / 8) * 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [pwps_pkg::CLK_W-1:0]   cfg_data,    // clock_hz
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [pwps_pkg::FREQ_W-1:0]  s_tdata,     // frequency
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [TDATA_W-1:0]           m_tdata      // prescale, period, exact, zero fill
);
	import pwps_pkg::*;

	state_t             state_q, state_d;
	logic [CLK_W-1:0]   clock_hz_q;
	logic [FREQ_W-1:0]  freq_q;
	logic [DVD_W-1:0]   count_q;
	logic [PSC_W-1:0]   d_q;
	logic               fit_found_q;
	logic [PSC_W-1:0]   fit_psc_q;
	logic [PER_W-1:0]   fit_per_q;
	logic [PSC_W-1:0]   res_psc_q;
	logic [PER_W-1:0]   res_per_q;
	logic               res_exact_q;
	logic               m_tvalid_q;
	logic [TDATA_W-1:0] m_tdata_q;

	logic               div_start;
	logic [DVD_W-1:0]   div_dividend;
	logic [DVSR_W-1:0]  div_divisor;
	logic               div_done;
	logic [DVD_W-1:0]   div_quot;
	logic [DVSR_W-1:0]  div_rem;

	logic               in_take;
	logic               out_free;
	logic               quot_lt;
	logic               rem_zero;
	logic               last_d;

	// Handshake and trial conditions.
	assign in_take  = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign quot_lt  = div_quot < DVD_W'(PERIOD_LIMIT);
	assign rem_zero = div_rem == '0;
	assign last_d   = d_q == PSC_W'(MAX_PRESCALE);

	// Shared divider for the total count and for every divisor trial.
	pwps_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_take) begin
					state_d = (s_tdata == '0) ? ST_DONE : ST_CNT_START;
				end
			end
			ST_CNT_START: state_d = ST_CNT_WAIT;
			ST_CNT_WAIT: begin
				if (div_done) begin
					state_d = ST_TRY_START;
				end
			end
			ST_TRY_START: state_d = ST_TRY_WAIT;
			ST_TRY_WAIT: begin
				if (div_done) begin
					state_d = ((quot_lt && rem_zero) || last_d) ? ST_DONE : ST_TRY_START;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		cfg_ready    = 1'b1;
		s_tready     = state_q == ST_IDLE;
		div_start    = (state_q == ST_CNT_START) || (state_q == ST_TRY_START);
		div_dividend = count_q;
		div_divisor  = {{(DVSR_W - PSC_W){1'b0}}, d_q};
		if (state_q == ST_CNT_START) begin
			div_dividend = clock_hz_q;
			div_divisor  = freq_q;
		end
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			clock_hz_q  <= CLOCK_RESET;
			fit_found_q <= 1'b0;
			m_tvalid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				clock_hz_q <= cfg_data;
			end
			if (state_q == ST_CNT_WAIT && div_done) begin
				fit_found_q <= 1'b0;
			end else if (state_q == ST_TRY_WAIT && div_done && quot_lt) begin
				fit_found_q <= 1'b1;
			end
			if (state_q == ST_DONE && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Datapath registers: count, divisor under trial, fallback fit and result.
	always_ff @(posedge clk) begin
		if (in_take) begin
			freq_q      <= s_tdata;
			res_psc_q   <= '0;
			res_per_q   <= '0;
			res_exact_q <= 1'b0;
		end
		if (state_q == ST_CNT_WAIT && div_done) begin
			count_q <= div_quot + DVD_W'(div_rem > ROUND_THR);
			d_q     <= PSC_W'(1);
		end
		if (state_q == ST_TRY_WAIT && div_done) begin
			if (quot_lt && !fit_found_q) begin
				fit_psc_q <= d_q;
				fit_per_q <= div_quot[PER_W-1:0];
			end
			if (quot_lt && rem_zero) begin
				res_psc_q   <= d_q;
				res_per_q   <= div_quot[PER_W-1:0];
				res_exact_q <= 1'b1;
			end else if (last_d) begin
				if (fit_found_q) begin
					res_psc_q <= fit_psc_q;
					res_per_q <= fit_per_q;
				end else if (quot_lt) begin
					res_psc_q <= d_q;
					res_per_q <= div_quot[PER_W-1:0];
				end
			end
			if (!last_d) begin
				d_q <= d_q + 1'b1;
			end
		end
		if (state_q == ST_DONE && out_free) begin
			m_tdata_q <= TDATA_W'({res_exact_q, res_per_q, res_psc_q});
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// An accepted request always moves the sequencer out of idle.
	a_take_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_take |=> state_q != ST_IDLE)
		else $error("request accepted but sequencer stayed idle");

	// The divider reports only while the sequencer waits for it.
	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_CNT_WAIT || state_q == ST_TRY_WAIT))
		else $error("divider result outside a wait state");

	// The divisor under trial stays within one and the prescaler limit.
	a_trial_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_TRY_WAIT |-> (d_q != '0 && d_q <= PSC_W'(MAX_PRESCALE)))
		else $error("trial divisor out of range");

	// An exact result never carries the zero prescaler of the error code.
	a_exact_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q && m_tdata_q[PSC_W + PER_W] |-> m_tdata_q[PSC_W-1:0] != '0)
		else $error("exact result with zero prescaler");

endmodule

`default_nettype wire

[tb/pwm_prescaler_period_search_unit_test.sv]
// Testbench for the PWM prescaler and period search unit.
// Drives frequency requests and clock settings, predicts each fit and checks every result.
// Depends on pwps_pkg and on the unit itself.
`timescale 1ns / 100ps

module pwm_prescaler_period_search_unit_test;
	import pwps_pkg::*;

	localparam int MAX_PRESCALE = 1200;
	localparam int PERIOD_LIMIT = 65535;
	localparam int PSC_W        = $clog2(MAX_PRESCALE + 1);
	localparam int TDATA_W      = ((PSC_W + PER_W + 1 + 7) / 8) * 8;
	localparam logic [CLK_W-1:0] CLOCK_MAX = {CLK_W{1'b1}};

	// One fit as the unit reports it.
	typedef struct packed {
		logic [PSC_W-1:0] prescale;
		logic [PER_W-1:0] period;
		logic             exact;
	} pwm_fit_t;

	// A fit still owed by the unit, with the request that caused it.
	typedef struct {
		logic [FREQ_W-1:0] frequency;
		pwm_fit_t          fit;
	} owed_fit_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [CLK_W-1:0]   cfg_data = '0;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	logic [FREQ_W-1:0]  s_tdata = '0;
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [TDATA_W-1:0] m_tdata;

	logic [CLK_W-1:0]   clock_setting = CLOCK_RESET;
	owed_fit_t          owed_fits[$];
	int                 mismatch_count = 0;
	int                 sender_calm = 0;

	pwm_prescaler_period_search_unit #(
		.MAX_PRESCALE(MAX_PRESCALE),
		.PERIOD_LIMIT(PERIOD_LIMIT)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),       // frequency
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)        // prescale, period, exact, zero fill
	);

	// 50 MHz clock.
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Computes the prescaler and period the unit should choose for one request.
	function automatic pwm_fit_t fit_for_frequency(input logic [CLK_W-1:0] clock_hz,
			input logic [FREQ_W-1:0] frequency);
		pwm_fit_t    fit;
		int unsigned total;
		int unsigned ratio;
		fit = '0;
		if (frequency == 0)
			return fit;
		total = clock_hz / frequency;
		if (clock_hz % frequency > ROUND_THR)
			total++;
		// First pass: a divisor that splits the count exactly.
		for (int unsigned d = 1; d <= MAX_PRESCALE; d++) begin
			ratio = total / d;
			if (total % d == 0 && ratio < PERIOD_LIMIT) begin
				fit.prescale = PSC_W'(d);
				fit.period   = PER_W'(ratio);
				fit.exact    = 1'b1;
				return fit;
			end
		end
		// Second pass: accept a truncated quotient.
		for (int unsigned d = 1; d <= MAX_PRESCALE; d++) begin
			ratio = total / d;
			if (ratio < PERIOD_LIMIT) begin
				fit.prescale = PSC_W'(d);
				fit.period   = PER_W'(ratio);
				return fit;
			end
		end
		// Nothing fits: error code of all zeros.
		return fit;
	endfunction

	// Draws a wait in cycles, with occasional stretches of back-to-back traffic.
	task automatic draw_wait(inout int calm_left, output int cycles);
		if (calm_left > 0) begin
			calm_left--;
			cycles = 0;
		end else if ($urandom_range(0, 11) == 0) begin
			calm_left = $urandom_range(4, 12);
			cycles = 0;
		end else begin
			cycles = $urandom_range(0, 13);
		end
	endtask

	task automatic report_mismatch(input string what, input int unsigned got,
			input int unsigned want, input logic [FREQ_W-1:0] frequency);
		$display("mismatch in %s: got %0d, expected %0d (frequency %0d)",
			what, got, want, frequency);
		mismatch_count++;
	endtask

	// Sends one frequency request and records the fit it is owed.
	task automatic send_frequency(input logic [FREQ_W-1:0] frequency);
		owed_fit_t owed;
		int        gap;
		draw_wait(sender_calm, gap);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= frequency;
		do @(posedge clk); while (!s_tready);
		owed.frequency = frequency;
		owed.fit       = fit_for_frequency(clock_setting, frequency);
		owed_fits.push_back(owed);
	endtask

	// Stops sending and waits until every owed fit has come back.
	task automatic settle_results();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (owed_fits.size() != 0);
	endtask

	// Writes the timer clock register while the unit is idle.
	task automatic write_clock_hz(input logic [CLK_W-1:0] value);
		settle_results();
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		clock_setting = value;
	endtask

	function automatic logic [FREQ_W-1:0] pick_frequency();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 4)
			return '0;
		if (roll < 8)
			return FREQ_W'($urandom_range(1, 1100));
		if (roll < 30)
			return FREQ_W'($urandom_range(0, 65535));
		return FREQ_W'($urandom_range(1100, 65535));
	endfunction

	// Receiver: stalls at random and checks each result against the oldest owed fit.
	initial begin
		int        stall;
		int        calm;
		pwm_fit_t  got;
		owed_fit_t owed;
		calm = 0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			draw_wait(calm, stall);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (m_tvalid !== 1'b1);
			got.prescale = m_tdata[PSC_W-1:0];
			got.period   = m_tdata[PSC_W +: PER_W];
			got.exact    = m_tdata[PSC_W + PER_W];
			if (owed_fits.size() == 0) begin
				report_mismatch("unrequested result prescale", got.prescale, 0, 0);
			end else begin
				owed = owed_fits.pop_front();
				if (got.prescale !== owed.fit.prescale)
					report_mismatch("prescale", got.prescale, owed.fit.prescale,
						owed.frequency);
				if (got.period !== owed.fit.period)
					report_mismatch("period", got.period, owed.fit.period, owed.frequency);
				if (got.exact !== owed.fit.exact)
					report_mismatch("exact", got.exact, owed.fit.exact, owed.frequency);
			end
		end
	end

	// Extremes of the frequency field at the reset clock.
	task automatic test_frequency_extremes();
		send_frequency(16'd1);
		send_frequency(16'd2);
		send_frequency(16'd65535);
		send_frequency(16'd65534);
		send_frequency(16'd1098);
		send_frequency(16'd1099);
		send_frequency(16'h5555);
		send_frequency(16'hAAAA);
	endtask

	// A zero frequency is refused with the all-zero error code.
	task automatic test_zero_frequency();
		send_frequency(16'd0);
		send_frequency(16'd1000);
		send_frequency(16'd0);
		send_frequency(16'd0);
	endtask

	// Large frequencies; some of them leave remainders above the rounding threshold.
	task automatic test_count_rounding();
		send_frequency(16'd40001);
		send_frequency(16'd32769);
		send_frequency(16'd65535);
	endtask

	// With a prime clock, frequency one gives a prime count with no exact split, so its fit is truncated.
	task automatic test_truncated_fit();
		write_clock_hz(27'd1000003);
		send_frequency(16'd1);
		send_frequency(16'd65535);
	endtask

	// At the largest clock even the widest prescaler leaves too long a period.
	task automatic test_no_fit();
		write_clock_hz(CLOCK_MAX);
		send_frequency(16'd1);
	endtask

	// A clock below the frequency here gives a zero count, fitted exactly by divisor one.
	task automatic test_zero_count();
		write_clock_hz('0);
		send_frequency(16'd1);
		send_frequency(16'd65535);
		write_clock_hz(27'd1000);
		send_frequency(16'd2000);
		send_frequency(16'd999);
	endtask

	// Random requests across several clock settings, extremes among them.
	task automatic test_random_traffic();
		logic [CLK_W-1:0] clocks[4];
		int               counts[4];
		clocks[0] = 27'd72000000;
		clocks[1] = 27'd1000000;
		clocks[2] = CLK_W'($urandom_range(1000000, 72000000));
		clocks[3] = CLOCK_MAX;
		counts = '{25, 20, 20, 13};
		for (int p = 0; p < 4; p++) begin
			write_clock_hz(clocks[p]);
			for (int i = 0; i < counts[p]; i++) begin
				// Hold off once mid-phase until the unit has drained.
				if (i == counts[p] / 2)
					settle_results();
				send_frequency(pick_frequency());
			end
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_frequency_extremes();
		test_zero_frequency();
		test_count_rounding();
		test_truncated_fit();
		test_no_fit();
		test_zero_count();
		test_random_traffic();
		settle_results();
		repeat (100) @(posedge clk);
		if (mismatch_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// Watchdog well past the slowest correct run.
	initial begin
		#(1_000_000_000);
		$display("end of test: mismatches");
		$finish;
	end

endmodule

[pwm_prescaler_period_search_unit.f]
hdl/pwps_pkg.sv
hdl/pwps_div.sv
hdl/pwm_prescaler_period_search_unit.sv
tb/pwm_prescaler_period_search_unit_test.sv
